// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the compensation rtl
// depends on nothing; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define PTC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define PTC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/ptc_pkg.sv -----
// shared types, constants and helper functions for the compensation block
// depends on nothing
package ptc_pkg;

    localparam int PTC_W = 32;

    localparam logic [1:0] PTC_REG_GROUP_A = 2'd0;
    localparam logic [1:0] PTC_REG_GROUP_B = 2'd1;
    localparam logic [1:0] PTC_REG_GROUP_C = 2'd2;
    localparam logic [1:0] PTC_REG_OSS     = 2'd3;

    localparam logic [31:0] PTC_T_OFFSET  = 32'd4000;
    localparam logic [31:0] PTC_X3_BIAS   = 32'd32768;
    localparam logic [31:0] PTC_P_SCALE   = 32'd50000;
    localparam logic [31:0] PTC_C_3038    = 32'd3038;
    localparam logic [31:0] PTC_C_7357    = 32'd7357;
    localparam logic [31:0] PTC_C_3791    = 32'd3791;

    // sideband carried through the temperature divider
    typedef struct packed {
        logic [18:0] up;
        logic [31:0] x1;
        logic        neg;
        logic        err;
    } ptc_side1_t;

    // sideband carried through the pressure divider
    typedef struct packed {
        logic [31:0] t;
        logic        big;
        logic        err;
    } ptc_side2_t;

    localparam int PTC_SIDE_W = $bits(ptc_side1_t);

    // working set of one item through the pipeline stages
    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
        logic [31:0] x1;
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] t;
        logic [31:0] b6;
        logic [31:0] sq;
        logic [31:0] ma2;
        logic [31:0] ma3;
        logic [31:0] s;
        logic [31:0] x2a;
        logic [31:0] x1b;
        logic [31:0] mb1;
        logic [31:0] mb2;
        logic [31:0] x3a;
        logic [31:0] x3b;
        logic [31:0] b3;
        logic [31:0] b4;
        logic [31:0] b7;
        logic [31:0] p;
        logic [31:0] mp;
        logic [31:0] m3;
        logic [31:0] x2q;
        logic [31:0] sum;
        logic        err;
    } ptc_item_t;

    // sign extend a 16-bit coefficient
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // signed division by 2^k truncating toward zero
    function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input logic [4:0] k);
        logic [31:0] bias;
        bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        return 32'($signed(a + bias) >>> k);
    endfunction

endpackage

// ----- rtl/core/ptc_div.sv -----
// pipelined unsigned 32-bit restoring divider, one quotient bit per stage
// depends on ptc_pkg for the width constants
module ptc_div
    import ptc_pkg::*;
#(
    parameter int SIDE_W = PTC_SIDE_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [PTC_W-1:0]  dividend,
    input  logic [PTC_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [PTC_W-1:0]  quotient,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg  [1:PTC_W];
    logic [PTC_W-1:0]  rem_reg  [1:PTC_W];
    logic [PTC_W-1:0]  dq_reg   [1:PTC_W];
    logic [PTC_W-1:0]  dvs_reg  [1:PTC_W];
    logic [SIDE_W-1:0] side_reg [1:PTC_W];

    for (genvar i = 1; i <= PTC_W; i++)
    begin : g_stage
        logic              vld_prev;
        logic [PTC_W-1:0]  rem_prev;
        logic [PTC_W-1:0]  dq_prev;
        logic [PTC_W-1:0]  dvs_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [PTC_W:0]    trial;
        logic [PTC_W:0]    diff;
        logic              ge;
        logic [PTC_W-1:0]  rem_next;
        logic [PTC_W-1:0]  dq_next;

        // the first stage takes the incoming transaction
        if (i == 1)
        begin : g_first
            assign vld_prev  = in_vld;
            assign rem_prev  = '0;
            assign dq_prev   = dividend;
            assign dvs_prev  = divisor;
            assign side_prev = side_in;
        end
        else
        begin : g_chain
            assign vld_prev  = vld_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign dq_prev   = dq_reg[i-1];
            assign dvs_prev  = dvs_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // one shift and trial subtract
        always_comb
        begin
            trial    = {rem_prev, dq_prev[PTC_W-1]};
            diff     = trial - {1'b0, dvs_prev};
            ge       = !diff[PTC_W];
            rem_next = ge ? diff[PTC_W-1:0] : trial[PTC_W-1:0];
            dq_next  = {dq_prev[PTC_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                dq_reg[i]   <= dq_next;
                dvs_reg[i]  <= dvs_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[PTC_W];
    assign quotient = dq_reg[PTC_W];
    assign side_out = side_reg[PTC_W];

endmodule

// ----- rtl/core/pressure_temperature_compensation_unit.sv -----
// Barometric pressure and temperature compensation, integer algorithm.
// Samples enter on the sample channel (sample_valid / sample_stall) as a raw
// temperature word and a raw pressure word already aligned for oversampling.
// Results leave on the result channel (result_valid / result_stall) as
// temperature in 0.1 degree C, pressure in Pa and a divide_error flag; on a
// zero divisor both values are zero and the flag is set.
// Calibration is written through cfg_valid / cfg_ready / cfg_index / cfg_data:
// index 0 and 1 take 64-bit coefficient groups, 2 a 32-bit group, 3 the
// oversampling setting. cfg_ready is always high; write only while idle.
// From an accepted sample to result_valid a sample passes 3 front
// stages, a 32-stage temperature divider, 8 stages of pressure terms, a
// 32-stage pressure divider, 4 correction stages and the output register.
// One sample is accepted per cycle while sample_stall is low. When the
// receiver stalls a held result, the whole pipeline freezes and
// sample_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and all calibration registers to zero.
`include "assert_macros.svh"

module pressure_temperature_compensation_unit
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic [15:0]        raw_temperature,
    input  logic [18:0]        raw_pressure,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] temperature,
    output logic signed [31:0] pressure,
    output logic               divide_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    // calibration registers
    logic [63:0] group_a_reg;
    logic [63:0] group_b_reg;
    logic [31:0] group_c_reg;
    logic [1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_a_reg <= '0;
            group_b_reg <= '0;
            group_c_reg <= '0;
            oss_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                PTC_REG_GROUP_A: group_a_reg <= cfg_data;
                PTC_REG_GROUP_B: group_b_reg <= cfg_data;
                PTC_REG_GROUP_C: group_c_reg <= cfg_data[31:0];
                PTC_REG_OSS:     oss_reg     <= cfg_data[1:0];
                default:         oss_reg     <= oss_reg;
            endcase
        end
    end

    // coefficient decode
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(group_a_reg[15:0]);
    assign ac2 = sx16(group_a_reg[31:16]);
    assign ac3 = sx16(group_a_reg[47:32]);
    assign ac4 = {16'd0, group_a_reg[63:48]};
    assign ac5 = {16'd0, group_b_reg[15:0]};
    assign ac6 = {16'd0, group_b_reg[31:16]};
    assign b1  = sx16(group_b_reg[47:32]);
    assign b2  = sx16(group_b_reg[63:48]);
    assign mc  = sx16(group_c_reg[15:0]);
    assign md  = sx16(group_c_reg[31:16]);

    // global advance: the pipeline moves unless a held result is stalled
    logic res_vld_reg;
    logic adv;
    assign adv          = !(res_vld_reg && result_stall);
    assign sample_stall = !adv;

    // stage registers
    logic      a_vld_reg, b_vld_reg, c_vld_reg;
    logic      e_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg;
    logic      i_vld_reg, j_vld_reg, k_vld_reg, l_vld_reg;
    logic      m_vld_reg, n_vld_reg, o_vld_reg, p_vld_reg;
    ptc_item_t a_reg, b_reg, c_reg, e_reg, f_reg, g_reg, h_reg;
    ptc_item_t i_reg, j_reg, k_reg, l_reg, m_reg, n_reg, o_reg, p_reg;
    ptc_item_t a_next, b_next, c_next, e_next, f_next, g_next, h_next;
    ptc_item_t i_next, j_next, k_next, l_next, m_next, n_next, o_next, p_next;

    logic        d1_vld, d2_vld;
    logic [31:0] d1_q, d2_q;
    logic [31:0] d1_dvd, d1_dvs, d2_dvd;
    ptc_side1_t  s1_in, s1_out;
    ptc_side2_t  s2_in, s2_out;

    logic [31:0] res_t_next, res_p_next;
    logic        res_err_next;
    logic [31:0] res_t_reg, res_p_reg;
    logic        res_err_reg;

    // capture of the raw words
    always_comb
    begin
        a_next    = '0;
        a_next.ut = raw_temperature;
        a_next.up = raw_pressure;
    end

    // uncompensated temperature product
    always_comb
    begin
        b_next    = a_reg;
        b_next.x1 = ({16'd0, a_reg.ut} - ac6) * ac5;
    end

    // x1, divider numerator and denominator
    always_comb
    begin
        c_next     = b_reg;
        c_next.x1  = sdiv_p2(b_reg.x1, 5'd15);
        c_next.den = c_next.x1 + md;
        c_next.num = mc << 11;
    end

    // temperature divider feed, on magnitudes
    always_comb
    begin
        d1_dvd     = c_reg.num[31] ? (32'd0 - c_reg.num) : c_reg.num;
        d1_dvs     = c_reg.den[31] ? (32'd0 - c_reg.den) : c_reg.den;
        s1_in.up   = c_reg.up;
        s1_in.x1   = c_reg.x1;
        s1_in.neg  = c_reg.num[31] ^ c_reg.den[31];
        s1_in.err  = (c_reg.den == 32'd0);
    end

    ptc_div #(.SIDE_W($bits(ptc_side1_t))) u_div_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (c_vld_reg),
        .dividend (d1_dvd),
        .divisor  (d1_dvs),
        .side_in  (s1_in),
        .out_vld  (d1_vld),
        .quotient (d1_q),
        .side_out (s1_out)
    );

    // b5, temperature result and b6
    always_comb
    begin
        logic [31:0] x2;
        logic [31:0] b5;
        x2         = s1_out.neg ? (32'd0 - d1_q) : d1_q;
        b5         = s1_out.x1 + x2;
        e_next     = '0;
        e_next.up  = s1_out.up;
        e_next.err = s1_out.err;
        e_next.t   = sdiv_p2(b5 + 32'd8, 5'd4);
        e_next.b6  = b5 - PTC_T_OFFSET;
    end

    // products of b6
    always_comb
    begin
        f_next     = e_reg;
        f_next.sq  = e_reg.b6 * e_reg.b6;
        f_next.ma2 = ac2 * e_reg.b6;
        f_next.ma3 = ac3 * e_reg.b6;
    end

    // scaled products
    always_comb
    begin
        g_next     = f_reg;
        g_next.s   = sdiv_p2(f_reg.sq, 5'd12);
        g_next.x2a = sdiv_p2(f_reg.ma2, 5'd11);
        g_next.x1b = sdiv_p2(f_reg.ma3, 5'd13);
    end

    // b1 and b2 terms
    always_comb
    begin
        h_next     = g_reg;
        h_next.mb2 = b2 * g_reg.s;
        h_next.mb1 = b1 * g_reg.s;
    end

    // x3 sums
    always_comb
    begin
        i_next     = h_reg;
        i_next.x3a = sdiv_p2(h_reg.mb2, 5'd11) + h_reg.x2a;
        i_next.x3b = h_reg.x1b + sdiv_p2(h_reg.mb1, 5'd16) + 32'd2;
    end

    // b3 and final x3
    always_comb
    begin
        j_next     = i_reg;
        j_next.b3  = sdiv_p2((((ac1 << 2) + i_reg.x3a) << oss_reg) + 32'd2, 5'd2);
        j_next.x3b = sdiv_p2(i_reg.x3b, 5'd2);
    end

    // b4 product and pressure offset
    always_comb
    begin
        k_next    = j_reg;
        k_next.b4 = ac4 * (j_reg.x3b + PTC_X3_BIAS);
        k_next.b7 = {13'd0, j_reg.up} - j_reg.b3;
    end

    // b4 and b7
    always_comb
    begin
        l_next    = k_reg;
        l_next.b4 = k_reg.b4 >> 15;
        l_next.b7 = k_reg.b7 * (PTC_P_SCALE >> oss_reg);
    end

    // pressure divider feed
    always_comb
    begin
        s2_in.t   = l_reg.t;
        s2_in.big = l_reg.b7[31];
        s2_in.err = l_reg.err || (l_reg.b4 == 32'd0);
        d2_dvd    = l_reg.b7[31] ? l_reg.b7 : (l_reg.b7 << 1);
    end

    ptc_div #(.SIDE_W($bits(ptc_side2_t))) u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (l_vld_reg),
        .dividend (d2_dvd),
        .divisor  (l_reg.b4),
        .side_in  (s2_in),
        .out_vld  (d2_vld),
        .quotient (d2_q),
        .side_out (s2_out)
    );

    // raw pressure and its scaled copy
    always_comb
    begin
        m_next     = '0;
        m_next.t   = s2_out.t;
        m_next.err = s2_out.err;
        m_next.p   = s2_out.big ? (d2_q << 1) : d2_q;
        m_next.x1  = sdiv_p2(m_next.p, 5'd8);
    end

    // correction products
    always_comb
    begin
        n_next    = m_reg;
        n_next.sq = m_reg.x1 * m_reg.x1;
        n_next.mp = (32'd0 - PTC_C_7357) * m_reg.p;
    end

    // second correction product
    always_comb
    begin
        o_next     = n_reg;
        o_next.m3  = n_reg.sq * PTC_C_3038;
        o_next.x2q = sdiv_p2(n_reg.mp, 5'd16);
    end

    // correction sum
    always_comb
    begin
        p_next     = o_reg;
        p_next.sum = sdiv_p2(o_reg.m3, 5'd16) + o_reg.x2q + PTC_C_3791;
    end

    // final result, zeroed on a divide error
    always_comb
    begin
        res_err_next = p_reg.err;
        res_t_next   = p_reg.err ? 32'd0 : p_reg.t;
        res_p_next   = p_reg.err ? 32'd0 : (p_reg.p + sdiv_p2(p_reg.sum, 5'd4));
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            j_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            l_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            n_vld_reg   <= 1'b0;
            o_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= sample_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            e_vld_reg   <= d1_vld;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
            i_vld_reg   <= h_vld_reg;
            j_vld_reg   <= i_vld_reg;
            k_vld_reg   <= j_vld_reg;
            l_vld_reg   <= k_vld_reg;
            m_vld_reg   <= d2_vld;
            n_vld_reg   <= m_vld_reg;
            o_vld_reg   <= n_vld_reg;
            p_vld_reg   <= o_vld_reg;
            res_vld_reg <= p_vld_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            c_reg       <= c_next;
            e_reg       <= e_next;
            f_reg       <= f_next;
            g_reg       <= g_next;
            h_reg       <= h_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            l_reg       <= l_next;
            m_reg       <= m_next;
            n_reg       <= n_next;
            o_reg       <= o_next;
            p_reg       <= p_next;
            res_t_reg   <= res_t_next;
            res_p_reg   <= res_p_next;
            res_err_reg <= res_err_next;
        end
    end

    assign result_valid = res_vld_reg;
    assign temperature  = res_t_reg;
    assign pressure     = res_p_reg;
    assign divide_error = res_err_reg;

    // a stalled result holds back the sample channel
    `PTC_ASSERT_IMPLY(a_stall_back, result_valid && result_stall, sample_stall)
    // no stall on the sample side without a stalled result
    `PTC_ASSERT_IMPLY(a_no_spurious_stall, !(result_valid && result_stall), !sample_stall)
    // an error result carries zero values
    `PTC_ASSERT_IMPLY(a_err_zero, result_valid && divide_error,
                      temperature == 32'sd0 && pressure == 32'sd0)

endmodule
